// ----- sv/single_wire_humidity_sensor_reader_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sensor reader checkers.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH

// same-cycle implication
`define SWHSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SWHSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/swhsr_pkg.sv -----
// ----------------------------------------------------------------------------
// swhsr_pkg
// Types and constants shared by the single-wire sensor reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swhsr_pkg;

  localparam int PULSE_COUNT_WIDTH = 16;
  localparam int DELAY_COUNT_WIDTH = 26;

  localparam int CFG_LONG_W  = 26;
  localparam int CFG_SHORT_W = 16;
  localparam int CFG_ATT_W   = 3;
  localparam int CFG_IDX_W   = 3;

  localparam int DCMP_W = (DELAY_COUNT_WIDTH > CFG_LONG_W) ? DELAY_COUNT_WIDTH : CFG_LONG_W;
  localparam int PCMP_W = (PULSE_COUNT_WIDTH > CFG_SHORT_W) ? PULSE_COUNT_WIDTH : CFG_SHORT_W;

  localparam logic [CFG_LONG_W-1:0]  RST_PRE_HIGH     = CFG_LONG_W'(250000);
  localparam logic [CFG_LONG_W-1:0]  RST_START_LOW    = CFG_LONG_W'(20000);
  localparam logic [CFG_SHORT_W-1:0] RST_RELEASE_HIGH = CFG_SHORT_W'(40);
  localparam logic [CFG_SHORT_W-1:0] RST_TIMEOUT      = CFG_SHORT_W'(120);
  localparam logic [CFG_LONG_W-1:0]  RST_RETRY_GAP    = CFG_LONG_W'(50000);
  localparam logic [CFG_ATT_W-1:0]   RST_MAX_ATTEMPTS = CFG_ATT_W'(3);

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
  localparam logic [1:0] ERR_CHECKSUM = 2'd2;

  typedef struct packed {
    logic [CFG_LONG_W-1:0]  pre_high_ticks;
    logic [CFG_LONG_W-1:0]  start_low_ticks;
    logic [CFG_SHORT_W-1:0] release_high_ticks;
    logic [CFG_SHORT_W-1:0] pulse_timeout_ticks;
    logic [CFG_LONG_W-1:0]  retry_gap_ticks;
    logic [CFG_ATT_W-1:0]   max_attempts;
  } cfg_t;

  typedef struct packed {
    logic       line_drive;
    logic       line_value;
    logic       busy_res;
    logic       done_res;
    logic       read_ok;
    logic [1:0] error_code;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/swhsr_cfg.sv -----
// ----------------------------------------------------------------------------
// swhsr_cfg
// Configuration register bank with plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module swhsr_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swhsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swhsr_pkg::CFG_LONG_W-1:0]     cfg_wdata_i,
  output swhsr_pkg::cfg_t                      cfg_o
);
  import swhsr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_PRE_HIGH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] IDX_START_LOW    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] IDX_RELEASE_HIGH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] IDX_TIMEOUT      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] IDX_RETRY_GAP    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] IDX_MAX_ATTEMPTS = CFG_IDX_W'(5);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_high_ticks      <= RST_PRE_HIGH;
      cfg_q.start_low_ticks     <= RST_START_LOW;
      cfg_q.release_high_ticks  <= RST_RELEASE_HIGH;
      cfg_q.pulse_timeout_ticks <= RST_TIMEOUT;
      cfg_q.retry_gap_ticks     <= RST_RETRY_GAP;
      cfg_q.max_attempts        <= RST_MAX_ATTEMPTS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        IDX_PRE_HIGH:     cfg_q.pre_high_ticks      <= cfg_wdata_i;
        IDX_START_LOW:    cfg_q.start_low_ticks     <= cfg_wdata_i;
        IDX_RELEASE_HIGH: cfg_q.release_high_ticks  <= cfg_wdata_i[CFG_SHORT_W-1:0];
        IDX_TIMEOUT:      cfg_q.pulse_timeout_ticks <= cfg_wdata_i[CFG_SHORT_W-1:0];
        IDX_RETRY_GAP:    cfg_q.retry_gap_ticks     <= cfg_wdata_i;
        IDX_MAX_ATTEMPTS: cfg_q.max_attempts        <= cfg_wdata_i[CFG_ATT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/swhsr_core.sv -----
// ----------------------------------------------------------------------------
// swhsr_core
// Sequencer for start signaling, pulse timing, bit capture and retries.
// ----------------------------------------------------------------------------
`default_nettype none

module swhsr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swhsr_pkg::cfg_t cfg_i,
  input  logic            step_i,
  input  logic            start_i,
  input  logic            level_i,
  output swhsr_pkg::res_t res_o
);
  import swhsr_pkg::*;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_STLOW = 4'd2;
  localparam logic [3:0] PH_REL   = 4'd3;
  localparam logic [3:0] PH_RLOW  = 4'd4;
  localparam logic [3:0] PH_RHIGH = 4'd5;
  localparam logic [3:0] PH_BLOW  = 4'd6;
  localparam logic [3:0] PH_BHIGH = 4'd7;
  localparam logic [3:0] PH_GAP   = 4'd8;

  localparam int         BITS_W    = 40;
  localparam logic [5:0] BIT_TOTAL = 6'd40;
  localparam logic [2:0] ATT_MAX   = 3'd7;

  logic [3:0]                   ph_q, ph_d;
  logic [DELAY_COUNT_WIDTH-1:0] dc_q, dc_d, dc_inc;
  logic [PULSE_COUNT_WIDTH-1:0] pc_q, pc_d, pc_inc;
  logic [PULSE_COUNT_WIDTH-1:0] slw_q, slw_d;
  logic [5:0]                   bc_q, bc_d, bc_inc;
  logic [BITS_W-1:0]            rb_q, rb_d, rb_new;
  logic [2:0]                   att_q, att_d, att_lim;
  logic [7:0]                   hum_q, hum_d, tmp_q, tmp_d;
  logic [1:0]                   lerr_q, lerr_d;

  logic [CFG_LONG_W-1:0] len;
  logic [3:0]            ent_p;
  logic                  ent_en;
  logic                  expect_hi;
  logic                  done, ok;
  logic [1:0]            err;
  logic [7:0]            csum;
  logic                  first_to;

  assign att_lim  = (cfg_i.max_attempts == '0) ? 3'd1 : cfg_i.max_attempts;
  assign dc_inc   = (dc_q == '1) ? dc_q : dc_q + 1'b1;
  assign pc_inc   = (pc_q == '1) ? pc_q : pc_q + 1'b1;
  assign bc_inc   = bc_q + 6'd1;
  assign rb_new   = {rb_q[BITS_W-2:0], (pc_q > slw_q)};
  assign csum     = rb_new[39:32] + rb_new[31:24] + rb_new[23:16] + rb_new[15:8];
  assign first_to = (cfg_i.pulse_timeout_ticks <= CFG_SHORT_W'(1));
  assign expect_hi = (ph_q == PH_RHIGH) || (ph_q == PH_BHIGH);

  always_comb begin
    unique case (ph_q)
      PH_PRE:   len = cfg_i.pre_high_ticks;
      PH_STLOW: len = cfg_i.start_low_ticks;
      PH_REL:   len = CFG_LONG_W'(cfg_i.release_high_ticks);
      default:  len = cfg_i.retry_gap_ticks;
    endcase
  end

  always_comb begin
    ph_d   = ph_q;
    dc_d   = dc_q;
    pc_d   = pc_q;
    slw_d  = slw_q;
    bc_d   = bc_q;
    rb_d   = rb_q;
    att_d  = att_q;
    hum_d  = hum_q;
    tmp_d  = tmp_q;
    lerr_d = lerr_q;
    done   = 1'b0;
    ok     = 1'b0;
    err    = ERR_NONE;
    ent_en = 1'b0;
    ent_p  = PH_IDLE;

    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          att_d  = '0;
          lerr_d = ERR_NONE;
          ent_en = 1'b1;
          ent_p  = PH_PRE;
        end
      end
      PH_PRE, PH_STLOW, PH_REL, PH_GAP: begin
        dc_d = dc_inc;
        if (DCMP_W'(dc_inc) >= DCMP_W'(len)) begin
          unique case (ph_q)
            PH_PRE:   begin ent_en = 1'b1; ent_p = PH_STLOW; end
            PH_STLOW: begin ent_en = 1'b1; ent_p = PH_REL;   end
            PH_REL:   begin ent_en = 1'b1; ent_p = PH_RLOW;  end
            default: begin
              if (att_q >= att_lim) begin
                ph_d = PH_IDLE;
                done = 1'b1;
                err  = lerr_q;
              end else begin
                ent_en = 1'b1;
                ent_p  = PH_PRE;
              end
            end
          endcase
        end
      end
      PH_RLOW, PH_RHIGH, PH_BLOW, PH_BHIGH: begin
        if (level_i == expect_hi) begin
          pc_d = pc_inc;
          if (PCMP_W'(pc_inc) >= PCMP_W'(cfg_i.pulse_timeout_ticks)) begin
            lerr_d = ERR_TIMEOUT;
            ent_en = 1'b1;
            ent_p  = PH_GAP;
          end
        end else if (pc_q == '0) begin
          lerr_d = ERR_TIMEOUT;
          ent_en = 1'b1;
          ent_p  = PH_GAP;
        end else begin
          // pulse ended: this sample opens the next pulse
          pc_d = PULSE_COUNT_WIDTH'(1);
          unique case (ph_q)
            PH_RLOW:  ph_d = PH_RHIGH;
            PH_RHIGH: ph_d = PH_BLOW;
            PH_BLOW: begin
              ph_d  = PH_BHIGH;
              slw_d = pc_q;
            end
            default: begin
              ph_d = PH_BLOW;
              rb_d = rb_new;
              bc_d = bc_inc;
            end
          endcase
          if ((ph_q == PH_BHIGH) && (bc_inc >= BIT_TOTAL)) begin
            if (csum != rb_new[7:0]) begin
              lerr_d = ERR_CHECKSUM;
              ent_en = 1'b1;
              ent_p  = PH_GAP;
            end else begin
              hum_d  = rb_new[39:32];
              tmp_d  = rb_new[23:16];
              lerr_d = ERR_NONE;
              ph_d   = PH_IDLE;
              done   = 1'b1;
              ok     = 1'b1;
            end
          end else if (first_to) begin
            lerr_d = ERR_TIMEOUT;
            ent_en = 1'b1;
            ent_p  = PH_GAP;
          end
        end
        if (ent_en) begin
          att_d = (att_q == ATT_MAX) ? ATT_MAX : att_q + 3'd1;
        end
      end
      default: ph_d = PH_IDLE;
    endcase

    // phase entry, skipping zero-length phases in the same tick
    if (ent_en) begin
      dc_d = '0;
      if (ent_p == PH_GAP) begin
        if (cfg_i.retry_gap_ticks != '0) begin
          ph_d  = PH_GAP;
          ent_p = PH_IDLE;
        end else if (att_d >= att_lim) begin
          ph_d  = PH_IDLE;
          done  = 1'b1;
          err   = lerr_d;
          ent_p = PH_IDLE;
        end else begin
          ent_p = PH_PRE;
        end
      end
      if (ent_p == PH_PRE) begin
        if (cfg_i.pre_high_ticks != '0) begin
          ph_d  = PH_PRE;
          ent_p = PH_IDLE;
        end else begin
          ent_p = PH_STLOW;
        end
      end
      if (ent_p == PH_STLOW) begin
        if (cfg_i.start_low_ticks != '0) begin
          ph_d  = PH_STLOW;
          ent_p = PH_IDLE;
        end else begin
          ent_p = PH_REL;
        end
      end
      if (ent_p == PH_REL) begin
        if (cfg_i.release_high_ticks != '0) begin
          ph_d  = PH_REL;
          ent_p = PH_IDLE;
        end else begin
          ent_p = PH_RLOW;
        end
      end
      if (ent_p == PH_RLOW) begin
        ph_d  = PH_RLOW;
        pc_d  = '0;
        slw_d = '0;
        bc_d  = '0;
        rb_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      dc_q   <= '0;
      pc_q   <= '0;
      slw_q  <= '0;
      bc_q   <= '0;
      rb_q   <= '0;
      att_q  <= '0;
      hum_q  <= '0;
      tmp_q  <= '0;
      lerr_q <= ERR_NONE;
    end else if (step_i) begin
      ph_q   <= ph_d;
      dc_q   <= dc_d;
      pc_q   <= pc_d;
      slw_q  <= slw_d;
      bc_q   <= bc_d;
      rb_q   <= rb_d;
      att_q  <= att_d;
      hum_q  <= hum_d;
      tmp_q  <= tmp_d;
      lerr_q <= lerr_d;
    end
  end

  always_comb begin
    res_o.line_drive  = (ph_d == PH_PRE) || (ph_d == PH_STLOW) || (ph_d == PH_REL);
    res_o.line_value  = (ph_d == PH_PRE) || (ph_d == PH_REL);
    res_o.busy_res    = (ph_d != PH_IDLE);
    res_o.done_res    = done;
    res_o.read_ok     = done && ok;
    res_o.error_code  = done ? err : ERR_NONE;
    res_o.humidity    = hum_d;
    res_o.temperature = tmp_d;
  end

endmodule

`default_nettype wire

// ----- sv/single_wire_humidity_sensor_reader.sv -----
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Host side of a single-wire humidity/temperature sensor link.
// ----------------------------------------------------------------------------
// Each input item is one line sample tick; each yields exactly one result item
// with the line drive request, busy/done status and the last good reading.
// Throughput is one item per clock while the result side does not stall. An
// accepted item waits in the input register while the sequencer works on it,
// and its result is registered in the result register that drives the output.
// Stalls on the result side back up through both registers, dropping no item.
// Configure only while the block is idle.
`default_nettype none

module single_wire_humidity_sensor_reader (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [swhsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swhsr_pkg::CFG_LONG_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             start_req_i,
  input  logic                             line_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             line_drive_o,
  output logic                             line_value_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic                             read_ok_o,
  output logic [1:0]                       error_code_o,
  output logic [7:0]                       humidity_o,
  output logic [7:0]                       temperature_o
);
  import swhsr_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;

  logic s1_valid_q;
  logic s1_start_q;
  logic s1_level_q;
  logic out_valid_q;
  logic adv;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  swhsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  swhsr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (adv),
    .start_i (s1_start_q),
    .level_i (s1_level_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_start_q <= start_req_i;
      s1_level_q <= line_level_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_drive_o  = res_q.line_drive;
  assign line_value_o  = res_q.line_value;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign read_ok_o     = res_q.read_ok;
  assign error_code_o  = res_q.error_code;
  assign humidity_o    = res_q.humidity;
  assign temperature_o = res_q.temperature;

endmodule

`default_nettype wire

// ----- sv/swhsr_checker.sv -----
// ----------------------------------------------------------------------------
// swhsr_checker
// Port-level checks on the sensor reader result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "single_wire_humidity_sensor_reader_macros.svh"

module swhsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       line_drive_o,
  input logic       line_value_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic       read_ok_o,
  input logic [1:0] error_code_o,
  input logic [7:0] humidity_o,
  input logic [7:0] temperature_o
);
  import swhsr_pkg::*;

  `SWHSR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable({line_drive_o, line_value_o, busy_res_o, done_res_o, read_ok_o, error_code_o, humidity_o, temperature_o}))
  `SWHSR_ASSERT_IMP(a_status_only_on_done, clk_i, rst_ni, out_valid_o && !done_res_o, !read_ok_o && (error_code_o == ERR_NONE))
  `SWHSR_ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o && !line_drive_o)
  `SWHSR_ASSERT_IMP(a_ok_no_error, clk_i, rst_ni, out_valid_o && read_ok_o, error_code_o == ERR_NONE)
  `SWHSR_ASSERT_IMP(a_released_low, clk_i, rst_ni, out_valid_o && !line_drive_o, !line_value_o)

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (.*);

`default_nettype wire

// ----- test/single_wire_humidity_sensor_reader_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Single-wire sensor reader testbench
// Streams line samples through the valid/ready input and checks every status
// item against a cycle model of the host sequencer. The line responses are
// built as sensor frames (good, bad checksum, timed out, missing) with
// retries, mixed with noise, under several register settings.
// ----------------------------------------------------------------------------

module tb;
  import swhsr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_CAP   = 100;
  localparam logic [CFG_LONG_W-1:0] LONG_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_HIGH, REG_START_LOW, REG_RELEASE_HIGH,
    REG_PULSE_TIMEOUT, REG_RETRY_GAP, REG_MAX_ATTEMPTS
  } cfg_reg_e;

  typedef enum logic [3:0] {
    RD_IDLE, RD_PRE, RD_STLOW, RD_REL, RD_RLOW, RD_RHIGH, RD_BLOW, RD_BHIGH, RD_GAP
  } rd_phase_e;

  typedef enum logic [1:0] {FR_GOOD, FR_BADSUM, FR_TIMEOUT, FR_MISSING} frame_e;

  typedef struct packed {
    logic start_req;
    logic line_level;
  } sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_LONG_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  start_req_i = 1'b0;
  logic                  line_level_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  line_drive_o;
  logic                  line_value_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic                  read_ok_o;
  logic [1:0]            error_code_o;
  logic [7:0]            humidity_o;
  logic [7:0]            temperature_o;

  single_wire_humidity_sensor_reader dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .line_level_i (line_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_drive_o (line_drive_o),
    .line_value_o (line_value_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_ok_o    (read_ok_o),
    .error_code_o (error_code_o),
    .humidity_o   (humidity_o),
    .temperature_o(temperature_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_t tick_q[$];
  res_t    line_status_q[$];
  int      n_pushed = 0;
  int      n_checked = 0;
  int      errors = 0;
  int      cyc = 0;
  logic    calm;

  assign calm = (cyc >= 300) && (cyc < 600);

  // register copies
  logic [CFG_LONG_W-1:0]  c_pre = RST_PRE_HIGH;
  logic [CFG_LONG_W-1:0]  c_low = RST_START_LOW;
  logic [CFG_SHORT_W-1:0] c_rel = RST_RELEASE_HIGH;
  logic [CFG_SHORT_W-1:0] c_tmo = RST_TIMEOUT;
  logic [CFG_LONG_W-1:0]  c_gap = RST_RETRY_GAP;
  logic [CFG_ATT_W-1:0]   c_att = RST_MAX_ATTEMPTS;

  // sequencer state
  rd_phase_e                    rd_ph = RD_IDLE;
  logic [DELAY_COUNT_WIDTH-1:0] dly = '0;
  logic [PULSE_COUNT_WIDTH-1:0] pcnt = '0;
  logic [PULSE_COUNT_WIDTH-1:0] low_w = '0;
  int unsigned                  nbits = 0;
  logic [39:0]                  rx_bits = '0;
  int unsigned                  tries = 0;
  logic [7:0]                   hum = '0;
  logic [7:0]                   temp = '0;
  logic [1:0]                   last_err = ERR_NONE;
  logic                         done_f, ok_f;
  logic [1:0]                   err_f;

  function automatic int unsigned att_limit();
    return (c_att == 0) ? 1 : c_att;
  endfunction

  function automatic void finish_read(logic ok, logic [1:0] err);
    rd_ph  = RD_IDLE;
    done_f = 1'b1;
    ok_f   = ok;
    err_f  = err;
  endfunction

  // zero-length drive phases and gap fall through in the same tick
  function automatic void enter_phase(rd_phase_e p);
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      dly = '0;
      settled = 1'b1;
      case (p)
        RD_PRE: if (c_pre == 0) begin
          p = RD_STLOW;
          settled = 1'b0;
        end
        RD_STLOW: if (c_low == 0) begin
          p = RD_REL;
          settled = 1'b0;
        end
        RD_REL: if (c_rel == 0) begin
          p = RD_RLOW;
          settled = 1'b0;
        end
        RD_GAP: if (c_gap == 0) begin
          if (tries >= att_limit()) begin
            finish_read(1'b0, last_err);
            return;
          end
          p = RD_PRE;
          settled = 1'b0;
        end
        RD_RLOW: begin
          pcnt = '0;
          low_w = '0;
          nbits = 0;
          rx_bits = '0;
        end
        default: ;
      endcase
    end
    rd_ph = p;
  endfunction

  function automatic void fail_attempt(logic [1:0] err);
    last_err = err;
    if (tries < 7) tries++;
    enter_phase(RD_GAP);
  endfunction

  // the edge sample is the first sample of the new pulse
  function automatic void next_pulse(rd_phase_e p);
    rd_ph = p;
    pcnt = 1;
    if (pcnt >= c_tmo) fail_attempt(ERR_TIMEOUT);
  endfunction

  function automatic void timed_step(logic [CFG_LONG_W-1:0] len, rd_phase_e nxt);
    if (dly != '1) dly = dly + 1'b1;
    if (dly >= len) begin
      if (nxt == RD_PRE && tries >= att_limit()) finish_read(1'b0, last_err);
      else enter_phase(nxt);
    end
  endfunction

  function automatic res_t advance_reader(logic start, logic level);
    res_t                         r;
    logic                         want;
    logic [PULSE_COUNT_WIDTH-1:0] w;
    logic [7:0]                   sum8;
    done_f = 1'b0;
    ok_f = 1'b0;
    err_f = ERR_NONE;
    case (rd_ph)
      RD_IDLE: if (start) begin
        tries = 0;
        last_err = ERR_NONE;
        enter_phase(RD_PRE);
      end
      RD_PRE:   timed_step(c_pre, RD_STLOW);
      RD_STLOW: timed_step(c_low, RD_REL);
      RD_REL:   timed_step(CFG_LONG_W'(c_rel), RD_RLOW);
      RD_GAP:   timed_step(c_gap, RD_PRE);
      default: begin
        want = (rd_ph == RD_RHIGH) || (rd_ph == RD_BHIGH);
        w = pcnt;
        if (level == want) begin
          if (pcnt != '1) pcnt = pcnt + 1'b1;
          if (pcnt >= c_tmo) fail_attempt(ERR_TIMEOUT);
        end else if (w == 0) begin
          fail_attempt(ERR_TIMEOUT);
        end else begin
          case (rd_ph)
            RD_RLOW:  next_pulse(RD_RHIGH);
            RD_RHIGH: next_pulse(RD_BLOW);
            RD_BLOW: begin
              low_w = w;
              next_pulse(RD_BHIGH);
            end
            default: begin
              rx_bits = {rx_bits[38:0], (w > low_w)};
              nbits++;
              sum8 = rx_bits[39:32] + rx_bits[31:24] + rx_bits[23:16] + rx_bits[15:8];
              if (nbits < 40) next_pulse(RD_BLOW);
              else if (sum8 != rx_bits[7:0]) fail_attempt(ERR_CHECKSUM);
              else begin
                hum = rx_bits[39:32];
                temp = rx_bits[23:16];
                last_err = ERR_NONE;
                finish_read(1'b1, ERR_NONE);
              end
            end
          endcase
        end
      end
    endcase
    r.line_drive  = (rd_ph == RD_PRE) || (rd_ph == RD_STLOW) || (rd_ph == RD_REL);
    r.line_value  = (rd_ph == RD_PRE) || (rd_ph == RD_REL);
    r.busy_res    = (rd_ph != RD_IDLE);
    r.done_res    = done_f;
    r.read_ok     = done_f && ok_f;
    r.error_code  = done_f ? err_f : ERR_NONE;
    r.humidity    = hum;
    r.temperature = temp;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : feed
    sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        line_status_q.push_back(advance_reader(start_req_i, line_level_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
          nxt = tick_q.pop_front();
          in_valid_i <= 1'b1;
          start_req_i <= nxt.start_req;
          line_level_i <= nxt.line_level;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (errors < PRINT_CAP) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
      errors++;
    end
  endtask

  // monitor
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : collect
    res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (line_status_q.size() == 0) begin
          if (errors < PRINT_CAP) $display("%0t: status item with none pending", $time);
          errors++;
        end else begin
          want = line_status_q.pop_front();
          cmp_field("line_drive", want.line_drive, line_drive_o);
          cmp_field("line_value", want.line_value, line_value_o);
          cmp_field("busy_res", want.busy_res, busy_res_o);
          cmp_field("done_res", want.done_res, done_res_o);
          cmp_field("read_ok", want.read_ok, read_ok_o);
          cmp_field("error_code", want.error_code, error_code_o);
          cmp_field("humidity", want.humidity, humidity_o);
          cmp_field("temperature", want.temperature, temperature_o);
          n_checked++;
        end
      end
      // one long hold-off so the input side backs up
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && n_checked >= 50 && tick_q.size() >= 16) begin
        hold_done <= 1'b1;
        hold_left <= 63;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // watchdog
  int quiet = 0;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("single_wire_humidity_sensor_reader: mismatch");
      $finish;
    end
  end

  // stimulus
  task automatic push_tick(logic st, logic lv);
    sample_t s;
    s.start_req = st;
    s.line_level = lv;
    tick_q.push_back(s);
    n_pushed++;
  endtask

  function automatic logic busy_start();
    return $urandom_range(3) == 0;
  endfunction

  task automatic send_span(int unsigned n);
    repeat (n) push_tick(busy_start(), $urandom_range(1));
  endtask

  task automatic send_pulse(logic lvl, int unsigned n);
    repeat (n) push_tick(busy_start(), lvl);
  endtask

  task automatic drain();
    wait (n_checked == n_pushed);
    @(negedge clk_i);
  endtask

  task automatic settle();
    drain();
    while (rd_ph != RD_IDLE) begin
      repeat (16) push_tick(1'b0, $urandom_range(1));
      drain();
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_LONG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  // one response frame; a timed-out pulse ends it early
  task automatic send_frame(frame_e kind);
    logic [39:0] word;
    logic [7:0]  sum8;
    logic        lvl, bitv;
    int unsigned top_w, lw, wd, cut;
    int          k;
    if (kind == FR_MISSING) begin
      push_tick(busy_start(), 1'b1);
      return;
    end
    top_w = (c_tmo > 7) ? 6 : ((c_tmo > 1) ? c_tmo - 1 : 1);
    word[39:8] = $urandom;
    sum8 = word[39:32] + word[31:24] + word[23:16] + word[15:8];
    word[7:0] = (kind == FR_BADSUM) ? sum8 + 8'($urandom_range(255, 1)) : sum8;
    cut = (kind == FR_TIMEOUT) ? $urandom_range(81) : 82;
    lw = 1;
    for (k = 0; k < 82; k++) begin
      lvl = k[0];
      if (k < 2) begin
        wd = $urandom_range(top_w, 1);
      end else begin
        bitv = word[39 - (k - 2) / 2];
        if (!lvl) begin
          lw = (bitv && top_w > 1) ? $urandom_range(top_w - 1, 1) : $urandom_range(top_w, 1);
          wd = lw;
        end else if (bitv) begin
          wd = (lw < top_w) ? $urandom_range(top_w, lw + 1) : top_w;
        end else begin
          wd = $urandom_range(lw, 1);
        end
      end
      if (k == cut) begin
        send_pulse(lvl, c_tmo);
        return;
      end
      send_pulse(lvl, wd);
    end
    push_tick(busy_start(), 1'b0);
  endtask

  task automatic run_reading();
    int unsigned a, r;
    frame_e      kind;
    push_tick(1'b1, $urandom_range(1));
    for (a = 1; a <= 8; a++) begin
      send_span(c_pre + c_low + c_rel);
      r = $urandom_range(99);
      kind = (r < 60) ? FR_GOOD : (r < 75) ? FR_BADSUM : (r < 90) ? FR_TIMEOUT : FR_MISSING;
      if (kind == FR_TIMEOUT && c_tmo > 64) kind = FR_MISSING;
      send_frame(kind);
      if (kind == FR_GOOD) break;
      send_span(c_gap);
      if (a >= att_limit()) break;
    end
    repeat ($urandom_range(3)) push_tick(1'b0, $urandom_range(1));
  endtask

  task automatic run_setting(logic [CFG_LONG_W-1:0] pre, logic [CFG_LONG_W-1:0] low,
                             logic [CFG_SHORT_W-1:0] rel, logic [CFG_SHORT_W-1:0] tmo,
                             logic [CFG_LONG_W-1:0] gap, logic [CFG_ATT_W-1:0] att,
                             int readings);
    int i;
    settle();
    write_reg(REG_PRE_HIGH, pre);
    write_reg(REG_START_LOW, low);
    write_reg(REG_RELEASE_HIGH, CFG_LONG_W'(rel));
    write_reg(REG_PULSE_TIMEOUT, CFG_LONG_W'(tmo));
    write_reg(REG_RETRY_GAP, gap);
    write_reg(REG_MAX_ATTEMPTS, CFG_LONG_W'(att));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    c_pre = pre;
    c_low = low;
    c_rel = rel;
    c_tmo = tmo;
    c_gap = gap;
    c_att = att;
    @(negedge clk_i);
    for (i = 0; i < readings; i++) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(60, 5)) push_tick($urandom_range(1), $urandom_range(1));
        settle();
      end
      run_reading();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, no start
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);

    // pre-high and release phases of zero length, timeout of one, no gap, single attempt
    run_setting('0, 1, '0, 1, '0, 1, 0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);

    // first response pulse missing; start on the done tick is ignored
    run_setting('0, 1, '0, 4, '0, 1, 0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);

    run_setting(2, 1, 1, 3, 2, 3, 1);
    run_setting('0, 1, '0, 3, '0, 7, 1);
    run_setting(1, 3, 2, '1, 1, 1, 0);
    run_setting(1, 2, '1, 6, 3, 1, 0);
    run_setting(LONG_MAX, LONG_MAX, 1, 1, LONG_MAX, 7, 0);
    repeat (8) push_tick(1'b0, $urandom_range(1));
    run_setting(3, 1, '0, 2, '0, 4, 1);
    run_setting(1, 1, 1, 8, 1, 2, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && line_status_q.size() == 0) begin
      $display("single_wire_humidity_sensor_reader: match");
    end else begin
      $display("single_wire_humidity_sensor_reader: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/swhsr_pkg.sv
sv/swhsr_cfg.sv
sv/swhsr_core.sv
sv/single_wire_humidity_sensor_reader.sv
sv/swhsr_checker.sv
test/single_wire_humidity_sensor_reader_tb.sv
